// File: sv/yrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_pkg: shared types, constants and functions of the YUV 4:2:0 to RGB unit
// Holds the frame size limits, the Q10 coefficients, the word format passed
// between the front and back parts, and the size fitting and clamp helpers.
// ----------------------------------------------------------------------------
package yrc_pkg;

	// Largest line width and frame height in use.
	localparam int MAX_LINE_WIDTH = 1024;
	localparam int HALF_LINE      = MAX_LINE_WIDTH / 2;

	// Column and row counters, size registers and line store address.
	localparam int POS_W  = $clog2(MAX_LINE_WIDTH);
	localparam int SIZE_W = POS_W + 1;
	localparam int SLOT_W = $clog2(HALF_LINE);

	// Configuration port.
	localparam int CFG_W = 11;
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LINE_WIDTH   = 1'b0;
	localparam cfg_idx_t CFG_FRAME_HEIGHT = 1'b1;

	// Q10 coefficients of the BT.601 studio-range conversion.
	localparam int K_Y  = 1192;
	localparam int K_RV = 1634;
	localparam int K_GV = 833;
	localparam int K_GU = 400;
	localparam int K_BU = 2066;
	localparam int FRAC_BITS = 10;
	localparam int CH_MAX    = 254;
	localparam int Y_OFFSET  = 16;
	localparam int C_OFFSET  = 128;

	// Accumulator wide enough for any sum of products.
	localparam int ACC_W = 22;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [8:0] smp_t;

	// Depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH) + 1;

	// One pixel after the front part: luma, its chroma pair and the marks.
	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] cb;
		logic [7:0] cr;
		logic       eol;
		logic       eof;
	} item_t;

	// Bring a written size into 2..MAX_LINE_WIDTH and make it even.
	function automatic logic [SIZE_W-1:0] fit_size(input logic [CFG_W-1:0] v);
		logic [SIZE_W-1:0] s;
		if (v < CFG_W'(2)) begin
			s = SIZE_W'(2);
		end else if (32'(v) > MAX_LINE_WIDTH) begin
			s = SIZE_W'(MAX_LINE_WIDTH);
		end else begin
			s = SIZE_W'(v);
		end
		s[0] = 1'b0;
		return s;
	endfunction

	// Floor a Q10 sum to an integer and clamp it to 0..CH_MAX.
	function automatic logic [7:0] to_channel(input acc_t sum);
		logic [ACC_W-FRAC_BITS-1:0] q;
		logic [7:0]                 c;
		q = sum[ACC_W-1:FRAC_BITS];
		if (sum < 0) begin
			c = 8'd0;
		end else if (32'(q) > CH_MAX) begin
			c = 8'(CH_MAX);
		end else begin
			c = q[7:0];
		end
		return c;
	endfunction

endpackage

// File: sv/yrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module yrc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/yrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_front: input side of the YUV 4:2:0 to RGB unit
// Accepts pixels, tracks the raster position, writes or reads the chroma
// line store and hands each pixel with its chroma pair to the queue.
// ----------------------------------------------------------------------------
module yrc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  yrc_pkg::cfg_idx_t         cfg_index,
	input  logic [yrc_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [23:0]               s_axis_tdata,
	input  logic                      s_axis_tuser,
	input  logic [yrc_pkg::QCNT_W-1:0] q_count,
	output logic                      push,
	output yrc_pkg::item_t            push_item
);
	import yrc_pkg::*;

	logic [SIZE_W-1:0] line_width_q;
	logic [SIZE_W-1:0] frame_height_q;
	logic [POS_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;

	logic              accept;
	logic [POS_W-1:0]  col_eff;
	logic [POS_W-1:0]  row_eff;
	logic              is_write;
	logic [SLOT_W-1:0] slot;
	logic              eol;
	logic              eof;
	logic [15:0]       rdata;

	logic              valid_s1;
	logic              wr_s1;
	logic [7:0]        luma_s1;
	logic [7:0]        cb_s1;
	logic [7:0]        cr_s1;
	logic              eol_s1;
	logic              eof_s1;

	// Room for this word and the one already in flight to the queue.
	assign s_axis_tready = (32'(q_count) + 32'(valid_s1)) < QUEUE_DEPTH;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= fit_size(CFG_W'(640));
			frame_height_q <= fit_size(CFG_W'(480));
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_WIDTH:   line_width_q   <= fit_size(cfg_data);
				CFG_FRAME_HEIGHT: frame_height_q <= fit_size(cfg_data);
				default: ;
			endcase
		end
	end

	// Position of this pixel; a frame start restarts at the top left.
	always_comb begin
		col_eff  = s_axis_tuser ? '0 : col_q;
		row_eff  = s_axis_tuser ? '0 : row_q;
		is_write = !row_eff[0] && !col_eff[0];
		slot     = col_eff[POS_W-1:1];
		eol      = (SIZE_W'(col_eff) + SIZE_W'(1)) >= line_width_q;
		eof      = eol && ((SIZE_W'(row_eff) + SIZE_W'(1)) >= frame_height_q);
	end

	// Raster position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (eol) begin
				col_q <= '0;
				row_q <= eof ? '0 : row_eff + POS_W'(1);
			end else begin
				col_q <= col_eff + POS_W'(1);
				row_q <= row_eff;
			end
		end
	end

	// Chroma line store: even rows at even columns write, all else reads.
	// Each entry holds Cb in the high byte and Cr in the low byte.
	yrc_ram #(
		.WIDTH(16),
		.DEPTH(HALF_LINE)
	) u_line_store (
		.clk  (clk),
		.we   (accept && is_write),
		.waddr(slot),
		.wdata({s_axis_tdata[15:8], s_axis_tdata[23:16]}),
		.re   (accept && !is_write),
		.raddr(slot),
		.rdata(rdata)
	);

	// Stage one: waits for the line store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1   <= is_write;
			luma_s1 <= s_axis_tdata[7:0];
			cb_s1   <= s_axis_tdata[15:8];
			cr_s1   <= s_axis_tdata[23:16];
			eol_s1  <= eol;
			eof_s1  <= eof;
		end
	end

	// Word to the queue, with the chroma pair from the input or the store.
	always_comb begin
		push           = valid_s1;
		push_item.luma = luma_s1;
		push_item.cb   = wr_s1 ? cb_s1 : rdata[15:8];
		push_item.cr   = wr_s1 ? cr_s1 : rdata[7:0];
		push_item.eol  = eol_s1;
		push_item.eof  = eof_s1;
	end

endmodule

// File: sv/yrc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_queue: short queue between the front and back parts
// Holds pixels with their chroma pairs so that each side may stall alone.
// ----------------------------------------------------------------------------
module yrc_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  yrc_pkg::item_t              push_item,
	input  logic                        pop,
	output yrc_pkg::item_t              head,
	output logic                        empty,
	output logic [yrc_pkg::QCNT_W-1:0]  count
);
	import yrc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head  = slot_q[rptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

endmodule

// File: sv/yrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_back: conversion side of the YUV 4:2:0 to RGB unit
// Multiplies by the Q10 coefficients, sums, floors and clamps each channel,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module yrc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  yrc_pkg::item_t head,
	input  logic           empty,
	output logic           pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [23:0]    m_axis_tdata,
	output logic           m_axis_tlast,
	output logic           m_axis_tuser
);
	import yrc_pkg::*;

	smp_t y;
	smp_t u;
	smp_t v;
	logic out_en;
	logic b1_en;

	logic valid_s1;
	acc_t ys_s1;
	acc_t rv_s1;
	acc_t gv_s1;
	acc_t gu_s1;
	acc_t bu_s1;
	logic eol_s1;
	logic eof_s1;

	logic valid_s2;
	acc_t sum_r;
	acc_t sum_g;
	acc_t sum_b;

	// Stall control: each stage moves when the one after it has room.
	assign out_en = !valid_s2 || m_axis_tready;
	assign b1_en  = !valid_s1 || out_en;
	assign pop    = b1_en && !empty;

	// Offset samples.
	always_comb begin
		y = smp_t'({1'b0, head.luma}) - smp_t'(Y_OFFSET);
		u = smp_t'({1'b0, head.cb}) - smp_t'(C_OFFSET);
		v = smp_t'({1'b0, head.cr}) - smp_t'(C_OFFSET);
	end

	// Stage one: coefficient products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (b1_en) begin
			valid_s1 <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ys_s1  <= acc_t'(y) * acc_t'(K_Y);
			rv_s1  <= acc_t'(v) * acc_t'(K_RV);
			gv_s1  <= acc_t'(v) * acc_t'(K_GV);
			gu_s1  <= acc_t'(u) * acc_t'(K_GU);
			bu_s1  <= acc_t'(u) * acc_t'(K_BU);
			eol_s1 <= head.eol;
			eof_s1 <= head.eof;
		end
	end

	// Channel sums.
	always_comb begin
		sum_r = ys_s1 + rv_s1;
		sum_g = ys_s1 - gv_s1 - gu_s1;
		sum_b = ys_s1 + bu_s1;
	end

	// Stage two: floor, clamp and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s1) begin
			m_axis_tdata <= {to_channel(sum_b), to_channel(sum_g), to_channel(sum_r)};
			m_axis_tlast <= eol_s1;
			m_axis_tuser <= eof_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;

endmodule

// File: sv/yuv420_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path: a pixel accepted at the input passes the line store read register,
// the queue and the coefficient product register to the output register.
// Throughput: one pixel per cycle, sustained while the output is taken.
// A four-word queue between the front and back parts absorbs output stalls.
// Reset clears the raster position, the queue and all valid flags and loads
// sizes 640 by 480; the chroma line store is not cleared.
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_unit: YUV 4:2:0 to RGB converter, BT.601 studio
// Converts a raster pixel stream with 4:2:0 chroma to clamped RGB words,
// with end-of-line and end-of-frame marks.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration writes.
	input  logic                      cfg_we,
	input  yrc_pkg::cfg_idx_t         cfg_index,
	input  logic [yrc_pkg::CFG_W-1:0] cfg_data,
	// Pixel input.
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [23:0]               s_axis_tdata,  // luma, chroma_blue, chroma_red
	input  logic                      s_axis_tuser,  // start_frame
	// RGB output.
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [23:0]               m_axis_tdata,  // red, green, blue
	output logic                      m_axis_tlast,  // end_of_line
	output logic                      m_axis_tuser   // end_of_frame
);
	import yrc_pkg::*;

	logic              push;
	item_t             push_item;
	logic              pop;
	item_t             head;
	logic              empty;
	logic [QCNT_W-1:0] q_count;

	// Position tracking and chroma line store.
	yrc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_count      (q_count),
		.push         (push),
		.push_item    (push_item)
	);

	// Queue between the two parts.
	yrc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (q_count)
	);

	// Color conversion and output register.
	yrc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

// File: sv/yrc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_checker: port checks of the YUV 4:2:0 to RGB unit
// Watches the output stream for stall behavior, mark order and clamping.
// ----------------------------------------------------------------------------
module yrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// A stalled output word stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// The last pixel of a frame is also the last of its line.
	a_eof_eol: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("end of frame without end of line");

	// Every channel is clamped below the full byte value.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'hFF) && (m_axis_tdata[15:8] != 8'hFF)
			&& (m_axis_tdata[23:16] != 8'hFF))
		else $error("channel above clamp limit");

endmodule

bind yuv420_to_rgb_converter_unit yrc_checker u_chk (.*);

// File: tb/sv/yuv420_to_rgb_converter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_checker: RGB word scoreboard for the 4:2:0 converter
// Watches the configuration port and both stream channels. It keeps its own
// raster position, frame size and chroma line store, and from them predicts
// the RGB word of every accepted pixel. Each output word is compared field
// by field with the oldest prediction, and mismatches are counted.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_checker
	import yrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  cfg_idx_t             cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // luma, chroma_blue, chroma_red
	input  logic                 s_axis_tuser,  // start_frame
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [23:0]          m_axis_tdata,  // red, green, blue
	input  logic                 m_axis_tlast,  // end_of_line
	input  logic                 m_axis_tuser,  // end_of_frame
	output int                   mismatch_count,
	output int                   pending_words,
	output int                   words_checked
);

	// Q10 BT.601 studio-range coefficients and limits.
	localparam int COEF_Y     = 1192;
	localparam int COEF_R_CR  = 1634;
	localparam int COEF_G_CR  = 833;
	localparam int COEF_G_CB  = 400;
	localparam int COEF_B_CB  = 2066;
	localparam int CHAN_TOP   = 254;
	localparam int DIM_MAX    = MAX_LINE_WIDTH;
	localparam int PAIR_SLOTS = DIM_MAX / 2;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       eol;
		logic       eof;
	} rgb_word_t;

	rgb_word_t   expected_rgb_q[$];
	int unsigned line_width_cur;
	int unsigned frame_height_cur;
	int unsigned col_pos;
	int unsigned row_pos;
	// Cb in the high byte, Cr in the low byte, one entry per two columns.
	logic [15:0] chroma_pairs [PAIR_SLOTS];

	// A written size is held to 2..DIM_MAX and forced even.
	function automatic int unsigned fit_dimension(input logic [CFG_W-1:0] raw);
		int unsigned s;
		s = raw;
		if (s < 2) s = 2;
		if (s > DIM_MAX) s = DIM_MAX;
		return s & ~32'd1;
	endfunction

	// Floor a Q10 sum and clamp it to the channel range.
	function automatic logic [7:0] q10_to_channel(input int sum);
		int q;
		if (sum < 0) return 8'd0;
		q = sum / 1024;
		if (q > CHAN_TOP) q = CHAN_TOP;
		return 8'(q);
	endfunction

	// Convert one accepted pixel and advance the raster position.
	function automatic rgb_word_t convert_pixel(input logic sof, input logic [23:0] data);
		int          y_term;
		int          cb_term;
		int          cr_term;
		int          luma_q10;
		int unsigned slot;
		logic [15:0] pair;
		rgb_word_t   w;
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		slot = (col_pos >> 1) % PAIR_SLOTS;
		// Chroma is sampled only at even row, even column.
		if ((row_pos % 2 == 0) && (col_pos % 2 == 0)) begin
			pair = {data[15:8], data[23:16]};
			chroma_pairs[slot] = pair;
		end else begin
			pair = chroma_pairs[slot];
		end
		y_term   = int'(data[7:0]) - 16;
		cb_term  = int'(pair[15:8]) - 128;
		cr_term  = int'(pair[7:0]) - 128;
		luma_q10 = COEF_Y * y_term;
		w.red   = q10_to_channel(luma_q10 + COEF_R_CR * cr_term);
		w.green = q10_to_channel(luma_q10 - COEF_G_CR * cr_term - COEF_G_CB * cb_term);
		w.blue  = q10_to_channel(luma_q10 + COEF_B_CB * cb_term);
		// A position at or past the size counts as the last one.
		w.eol = (col_pos + 1 >= line_width_cur);
		w.eof = w.eol && (row_pos + 1 >= frame_height_cur);
		if (w.eol) begin
			col_pos = 0;
			row_pos = w.eof ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return w;
	endfunction

	// Register writes, prediction on input words, comparison on output words.
	always @(posedge clk or negedge arst_n) begin : monitor
		rgb_word_t want;
		rgb_word_t got;
		if (!arst_n) begin
			line_width_cur   = 640;
			frame_height_cur = 480;
			col_pos          = 0;
			row_pos          = 0;
			expected_rgb_q.delete();
			mismatch_count   = 0;
			pending_words    = 0;
			words_checked    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LINE_WIDTH: begin
						line_width_cur = fit_dimension(cfg_data);
					end
					CFG_FRAME_HEIGHT: begin
						frame_height_cur = fit_dimension(cfg_data);
					end
					default: begin
					end
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.red   = m_axis_tdata[7:0];
				got.green = m_axis_tdata[15:8];
				got.blue  = m_axis_tdata[23:16];
				got.eol   = m_axis_tlast;
				got.eof   = m_axis_tuser;
				if (expected_rgb_q.size() == 0) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display("ERROR: RGB word %0d arrived with no pixel waiting", words_checked);
					end
					mismatch_count++;
				end else begin
					want = expected_rgb_q.pop_front();
					if (got !== want) begin
						if (mismatch_count < MAX_REPORTS) begin
							$display("ERROR: RGB word %0d: expected R=%0d G=%0d B=%0d eol=%0b eof=%0b",
								words_checked, want.red, want.green, want.blue, want.eol, want.eof);
							$display("       got R=%0d G=%0d B=%0d eol=%0b eof=%0b",
								got.red, got.green, got.blue, got.eol, got.eof);
						end
						mismatch_count++;
					end
				end
				words_checked++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_rgb_q.push_back(convert_pixel(s_axis_tuser, s_axis_tdata));
			end
			pending_words = expected_rgb_q.size();
		end
	end

endmodule

// File: tb/sv/yuv420_to_rgb_converter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_to_rgb_converter_unit_test: stimulus and verdict for the converter
// Drives frame sizes and pixel streams into the converter under several idle
// and stall patterns, with a directed set of corner pixels first and random
// frames after it. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_converter_unit_test;
	import yrc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int MODE_SPAN   = 128;
	localparam int NUM_PHASES  = 7;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [23:0]      s_axis_tdata;  // luma, chroma_blue, chroma_red
	logic             s_axis_tuser;  // start_frame
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [23:0]      m_axis_tdata;  // red, green, blue
	logic             m_axis_tlast;  // end_of_line
	logic             m_axis_tuser;  // end_of_frame
	int               mismatch_count;
	int               pending_words;
	int               words_checked;

	int               idle_mode;
	int               pixels_sent;
	int               size_settings;

	// Random phases: raw size writes, pixels per frame, length, fresh start.
	int               phase_width  [NUM_PHASES];
	int               phase_height [NUM_PHASES];
	int               phase_pixels [NUM_PHASES];
	int               phase_items  [NUM_PHASES];
	int               phase_fresh  [NUM_PHASES];

	yuv420_to_rgb_converter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	yuv420_to_rgb_converter_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.m_axis_tuser   (m_axis_tuser),
		.mismatch_count (mismatch_count),
		.pending_words  (pending_words),
		.words_checked  (words_checked)
	);

	// 125 MHz clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle percentages of each pattern: none, sender, receiver, both.
	function automatic int sender_idle_pct(input int mode);
		case (mode)
			1: return 57;
			3: return 15;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(input int mode);
		case (mode)
			2: return 57;
			3: return 15;
			default: return 0;
		endcase
	endfunction

	// Bytes lean toward the extremes now and then.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Output side: ready follows the current stall pattern.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
		end
	end

	// Ends the run when neither channel moves a word for too long.
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one pixel, with random idle cycles ahead of it, until accepted.
	task automatic send_pixel(input logic sof, input logic [7:0] luma,
			input logic [7:0] cb, input logic [7:0] cr);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct(idle_mode)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {cr, cb, luma};
		s_axis_tuser  <= sof;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pixels_sent++;
		idle_mode = (pixels_sent / MODE_SPAN) % 4;
	endtask

	// Stop sending and wait until every predicted word has come out.
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
	endtask

	// Write both size registers while the block is idle.
	task automatic set_frame_size(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LINE_WIDTH;
		cfg_data  <= width;
		@(negedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data  <= height;
		@(negedge clk);
		cfg_we    <= 1'b0;
		size_settings++;
	endtask

	initial begin : stimulus
		int   ph;
		int   n;
		int   pos_in_frame;
		logic sof;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_LINE_WIDTH;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		idle_mode     = 0;
		pixels_sent   = 0;
		size_settings = 0;

		// The first phase writes every line store slot, so later phases may
		// carry a stale position across a size change without reading an
		// entry that was never written.
		phase_width  = '{2047, 7, 2, 4, 1025, 16, 10};
		phase_height = '{2000, 3, 17, 4, 480, 6, 2};
		phase_pixels = '{1024 * 1024, 6 * 2, 2 * 16, 4 * 4, 1024 * 480, 16 * 6, 10 * 2};
		phase_items  = '{1030, 120, 120, 120, 130, 120, 130};
		phase_fresh  = '{1, 0, 1, 0, 1, 1, 0};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corners on 2x2 frames; the size writes fall below the minimum.
		set_frame_size(11'd0, 11'd1);
		// Darkest chroma, then odd column and odd row reuse of the stored pair.
		send_pixel(1'b1, 8'd0,   8'd0,   8'd0);
		send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		send_pixel(1'b0, 8'd16,  8'd77,  8'd200);
		send_pixel(1'b0, 8'd235, 8'd3,   8'd9);
		// Brightest chroma saturates red and blue.
		send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
		send_pixel(1'b0, 8'd128, 8'd0,   8'd0);
		send_pixel(1'b0, 8'd235, 8'd17,  8'd33);
		send_pixel(1'b0, 8'd0,   8'd255, 8'd255);
		// Neutral chroma across the luma range.
		send_pixel(1'b1, 8'd128, 8'd128, 8'd128);
		send_pixel(1'b0, 8'd16,  8'd0,   8'd255);
		send_pixel(1'b0, 8'd235, 8'd255, 8'd0);
		send_pixel(1'b0, 8'd255, 8'd64,  8'd192);
		// Frame restart on an odd column.
		send_pixel(1'b1, 8'd100, 8'd0,   8'd255);
		send_pixel(1'b1, 8'd100, 8'd255, 8'd0);
		send_pixel(1'b0, 8'd200, 8'd1,   8'd1);
		send_pixel(1'b0, 8'd50,  8'd2,   8'd2);
		send_pixel(1'b0, 8'd180, 8'd3,   8'd3);
		// Next frame follows the end of frame without a start mark.
		send_pixel(1'b0, 8'd235, 8'd255, 8'd0);
		send_pixel(1'b0, 8'd16,  8'd128, 8'd128);
		send_pixel(1'b0, 8'd0,   8'd255, 8'd255);
		send_pixel(1'b0, 8'd255, 8'd0,   8'd0);
		// Typical saturated colors.
		send_pixel(1'b1, 8'd81,  8'd90,  8'd240);
		send_pixel(1'b0, 8'd145, 8'd54,  8'd34);
		send_pixel(1'b0, 8'd41,  8'd240, 8'd110);
		send_pixel(1'b0, 8'd255, 8'd0,   8'd0);

		// Random frames, each phase at a new size once the block is idle.
		// The first phase never restarts mid-line, so its first line is whole.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results();
			set_frame_size(CFG_W'(phase_width[ph]), CFG_W'(phase_height[ph]));
			pos_in_frame = phase_fresh[ph] ? 0 : 1;
			for (n = 0; n < phase_items[ph]; n++) begin
				if (pos_in_frame == 0) begin
					sof = (n == 0) ? 1'b1 : 1'($urandom_range(1));
				end else begin
					sof = (ph != 0) && ($urandom_range(99) < 2);
				end
				if (sof) pos_in_frame = 0;
				send_pixel(sof, pick_byte(), pick_byte(), pick_byte());
				pos_in_frame = (pos_in_frame + 1) % phase_pixels[ph];
			end
		end

		drain_results();
		repeat (16) @(posedge clk);

		$display("Run summary: %0d pixels over %0d frame size settings and four idle patterns,",
			pixels_sent, size_settings);
		$display("  %0d RGB words compared, %0d of them wrong.", words_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/yrc_pkg.sv
sv/yrc_ram.sv
sv/yrc_front.sv
sv/yrc_queue.sv
sv/yrc_back.sv
sv/yuv420_to_rgb_converter_unit.sv
sv/yrc_checker.sv
tb/sv/yuv420_to_rgb_converter_checker.sv
tb/sv/yuv420_to_rgb_converter_unit_test.sv
